// ===== src/go3_pkg.sv =====
// Shared types, constants and the 3x3 outline function for the glyph outline block.
`timescale 1ns / 1ps

package go3_pkg;

   localparam int WORD_W    = 16;  // pixels per bitmap word
   localparam int CSR_W     = 5;   // words_per_row register width
   localparam int EXT_W     = 7;   // holds a row length up to 126 words plus one
   localparam logic [CSR_W-1:0] WPR_RESET = 5'd1;

   // which result the datapath produces this cycle
   typedef enum logic [1:0] {
      EMIT_NONE,
      EMIT_MID,     // column j-1 of the row above the incoming word
      EMIT_ROW,     // last column of that row
      EMIT_FLUSH    // final row at end of image
   } emit_sel_type;

   typedef struct packed {
      logic         load;         // latch the accepted word
      logic         rd_en;        // read both row stores
      logic         wr_first;     // first row: middle <= word
      logic         shift_cache;  // column cache <= read data
      logic         set_prior;    // prior below word <= word
      logic         row_end;      // clear left-edge pixels
      logic         clear_all;    // end of image: back to blank state
      logic         flush_right;  // right neighbor comes from read data
      logic         flush_last;   // final result of the image
      emit_sel_type emit_sel;
   } ctl_cmd_type;

   // Outline of one word: clear pixel with any of its eight neighbors set.
   function automatic logic [WORD_W-1:0] outline_word(
      input logic [WORD_W-1:0] a,
      input logic [WORD_W-1:0] m,
      input logic [WORD_W-1:0] b,
      input logic              la,
      input logic              lm,
      input logic              lb,
      input logic              ra,
      input logic              rm,
      input logic              rb
   );
      logic [WORD_W+1:0] ea;
      logic [WORD_W+1:0] em;
      logic [WORD_W+1:0] eb;
      logic [WORD_W+1:0] n;
      ea = {la, a, ra};
      em = {lm, m, rm};
      eb = {lb, b, rb};
      n  = ea | (ea >> 1) | (ea >> 2) | eb | (eb >> 1) | (eb >> 2) | em | (em >> 2);
      return n[WORD_W-1:0] & ~m;
   endfunction

endpackage

// ===== src/go3_datapath.sv =====
// Row stores, column cache, outline logic and result register.
`timescale 1ns / 1ps

module go3_datapath import go3_pkg::*; #(
   parameter int MAX_ROW_WORDS = 16,
   parameter int IW = (MAX_ROW_WORDS > 1) ? $clog2(MAX_ROW_WORDS) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  ctl_cmd_type       cmd,
   input  logic [IW-1:0]     rd_addr,
   input  logic [IW-1:0]     wr_addr,
   input  logic [WORD_W-1:0] req_tdata,
   output logic              out_free,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [WORD_W-1:0] rsp_tdata,
   output logic              rsp_tlast
);

   logic [WORD_W-1:0] above_mem [MAX_ROW_WORDS];
   logic [WORD_W-1:0] middle_mem [MAX_ROW_WORDS];
   logic [MAX_ROW_WORDS-1:0] above_vld_ff, above_vld_in;

   logic [WORD_W-1:0] rd_above_ff, rd_middle_ff;
   logic              rd_avld_ff;
   logic [WORD_W-1:0] rd_above;

   logic [WORD_W-1:0] word_ff;
   logic [WORD_W-1:0] k_above_ff, k_middle_ff;
   logic [WORD_W-1:0] prior_below_ff, prior_below_in;
   logic              left_a_ff, left_a_in;
   logic              left_m_ff, left_m_in;
   logic              left_b_ff, left_b_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_data_ff;
   logic              rsp_last_ff;

   logic [WORD_W-1:0] op_below;
   logic              op_lb, op_ra, op_rm, op_rb;
   logic [WORD_W-1:0] result;
   logic              emit;
   logic              above_we, middle_we;
   logic [WORD_W-1:0] middle_wdata;

   // never-written above entries read as the blank top border
   assign rd_above = rd_avld_ff ? rd_above_ff : '0;
   assign emit     = (cmd.emit_sel != EMIT_NONE);
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      op_below = k_above_ff;
      op_lb    = left_b_ff;
      op_ra    = 1'b0;
      op_rm    = 1'b0;
      op_rb    = 1'b0;
      case (cmd.emit_sel)
         EMIT_MID: begin
            op_below = prior_below_ff;
            op_ra    = rd_above[WORD_W-1];
            op_rm    = rd_middle_ff[WORD_W-1];
            op_rb    = word_ff[WORD_W-1];
         end
         EMIT_ROW: begin
            op_below = word_ff;
         end
         EMIT_FLUSH: begin
            op_below = '0;
            op_lb    = 1'b0;
            op_ra    = cmd.flush_right & rd_above[WORD_W-1];
            op_rm    = cmd.flush_right & rd_middle_ff[WORD_W-1];
         end
         default: begin
            op_below = '0;
         end
      endcase
      result = outline_word(k_above_ff, k_middle_ff, op_below,
                            left_a_ff, left_m_ff, op_lb, op_ra, op_rm, op_rb);
   end

   always_comb begin
      above_we     = (cmd.emit_sel == EMIT_MID) || (cmd.emit_sel == EMIT_ROW);
      middle_we    = above_we || cmd.wr_first;
      middle_wdata = (cmd.emit_sel == EMIT_MID) ? prior_below_ff : word_ff;

      above_vld_in = above_vld_ff;
      if (cmd.clear_all) begin
         above_vld_in = '0;
      end else if (above_we) begin
         above_vld_in[wr_addr] = 1'b1;
      end

      prior_below_in = prior_below_ff;
      if (cmd.clear_all) begin
         prior_below_in = '0;
      end else if (cmd.set_prior) begin
         prior_below_in = word_ff;
      end

      left_a_in = left_a_ff;
      left_m_in = left_m_ff;
      left_b_in = left_b_ff;
      if (cmd.row_end || cmd.clear_all) begin
         left_a_in = 1'b0;
         left_m_in = 1'b0;
         left_b_in = 1'b0;
      end else if (cmd.emit_sel == EMIT_MID) begin
         left_a_in = k_above_ff[0];
         left_m_in = k_middle_ff[0];
         left_b_in = prior_below_ff[0];
      end else if (cmd.emit_sel == EMIT_FLUSH) begin
         left_a_in = k_above_ff[0];
         left_m_in = k_middle_ff[0];
      end

      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // row stores
   always_ff @(posedge clock) begin
      if (above_we) begin
         above_mem[wr_addr] <= k_middle_ff;
      end
      if (middle_we) begin
         middle_mem[wr_addr] <= middle_wdata;
      end
      if (cmd.rd_en) begin
         rd_above_ff  <= above_mem[rd_addr];
         rd_middle_ff <= middle_mem[rd_addr];
         rd_avld_ff   <= above_vld_ff[rd_addr];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         word_ff <= req_tdata;
      end
      if (cmd.shift_cache) begin
         k_above_ff  <= rd_above;
         k_middle_ff <= rd_middle_ff;
      end
      if (emit) begin
         rsp_data_ff <= result;
         rsp_last_ff <= (cmd.emit_sel == EMIT_FLUSH) && cmd.flush_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         above_vld_ff   <= '0;
         prior_below_ff <= '0;
         left_a_ff      <= 1'b0;
         left_m_ff      <= 1'b0;
         left_b_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         above_vld_ff   <= above_vld_in;
         prior_below_ff <= prior_below_in;
         left_a_ff      <= left_a_in;
         left_m_ff      <= left_m_in;
         left_b_ff      <= left_b_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== src/go3_ctrl.sv =====
// Sequencer: column and row tracking, row-length register and flush control.
`timescale 1ns / 1ps

module go3_ctrl import go3_pkg::*; #(
   parameter int MAX_ROW_WORDS = 16,
   parameter int IW = (MAX_ROW_WORDS > 1) ? $clog2(MAX_ROW_WORDS) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic             req_tlast,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CSR_W-1:0] csr_data,
   input  logic             out_free,
   output ctl_cmd_type      cmd,
   output logic [IW-1:0]    rd_addr,
   output logic [IW-1:0]    wr_addr
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_LAST,
      ST_FL_PRIME,
      ST_FL_LOAD,
      ST_FL_EMIT
   } state_type;

   state_type        state_ff, state_in;
   logic [IW-1:0]    col_ff, col_in;
   logic [IW-1:0]    fk_ff, fk_in;
   logic             row_seen_ff, row_seen_in;
   logic             last_ff, last_in;
   logic             end_ff, end_in;
   logic [CSR_W-1:0] words_ff, words_in;

   logic [EXT_W-1:0] words_ext, eff_width, col_next_ext;
   logic             ends_row;

   // row length as used: zero means one word, capped at the store depth
   always_comb begin
      words_ext    = EXT_W'(words_ff);
      col_next_ext = EXT_W'(col_ff) + EXT_W'(1);
      if (words_ext == '0) begin
         eff_width = EXT_W'(1);
      end else if (words_ext > EXT_W'(MAX_ROW_WORDS)) begin
         eff_width = EXT_W'(MAX_ROW_WORDS);
      end else begin
         eff_width = words_ext;
      end
      ends_row = (col_next_ext >= eff_width);
   end

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in    = state_ff;
      col_in      = col_ff;
      fk_in       = fk_ff;
      row_seen_in = row_seen_ff;
      last_in     = last_ff;
      end_in      = end_ff;
      words_in    = (csr_valid) ? csr_data : words_ff;
      cmd         = '0;
      cmd.emit_sel = EMIT_NONE;
      rd_addr     = col_ff;
      wr_addr     = col_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load  = 1'b1;
               cmd.rd_en = 1'b1;
               last_in   = ends_row;
               end_in    = req_tlast;
               state_in  = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (!row_seen_ff) begin
               cmd.wr_first = 1'b1;
               if (last_ff) begin
                  cmd.row_end = 1'b1;
                  row_seen_in = 1'b1;
                  if (end_ff) begin
                     state_in = ST_FL_PRIME;
                  end else begin
                     col_in   = '0;
                     state_in = ST_IDLE;
                  end
               end else begin
                  col_in   = col_ff + IW'(1);
                  state_in = ST_IDLE;
               end
            end else if (col_ff == '0 || out_free) begin
               // result for the column left of the incoming word
               if (col_ff != '0) begin
                  cmd.emit_sel = EMIT_MID;
               end
               wr_addr         = col_ff - IW'(1);
               cmd.shift_cache = 1'b1;
               cmd.set_prior   = 1'b1;
               if (last_ff) begin
                  state_in = ST_LAST;
               end else begin
                  col_in   = col_ff + IW'(1);
                  state_in = ST_IDLE;
               end
            end
         end
         ST_LAST: begin
            if (out_free) begin
               cmd.emit_sel = EMIT_ROW;
               cmd.row_end  = 1'b1;
               row_seen_in  = 1'b1;
               if (end_ff) begin
                  state_in = ST_FL_PRIME;
               end else begin
                  col_in   = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FL_PRIME: begin
            cmd.rd_en = 1'b1;
            rd_addr   = '0;
            state_in  = ST_FL_LOAD;
         end
         ST_FL_LOAD: begin
            cmd.rd_en       = 1'b1;
            cmd.shift_cache = 1'b1;
            rd_addr         = IW'(1);
            fk_in           = '0;
            state_in        = ST_FL_EMIT;
         end
         ST_FL_EMIT: begin
            // col_ff still holds the last column of the final row
            if (out_free) begin
               cmd.emit_sel    = EMIT_FLUSH;
               cmd.flush_right = (fk_ff != col_ff);
               cmd.flush_last  = (fk_ff == col_ff);
               cmd.shift_cache = 1'b1;
               cmd.rd_en       = 1'b1;
               rd_addr         = fk_ff + IW'(2);
               if (fk_ff == col_ff) begin
                  cmd.clear_all = 1'b1;
                  row_seen_in   = 1'b0;
                  col_in        = '0;
                  state_in      = ST_IDLE;
               end else begin
                  fk_in = fk_ff + IW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         col_ff      <= '0;
         fk_ff       <= '0;
         row_seen_ff <= 1'b0;
         last_ff     <= 1'b0;
         end_ff      <= 1'b0;
         words_ff    <= WPR_RESET;
      end else begin
         state_ff    <= state_in;
         col_ff      <= col_in;
         fk_ff       <= fk_in;
         row_seen_ff <= row_seen_in;
         last_ff     <= last_in;
         end_ff      <= end_in;
         words_ff    <= words_in;
      end
   end

endmodule

// ===== src/glyph_outline_3x3.sv =====
// Top level of the streaming 3x3 glyph outline block.
//
//  channel | direction | tdata (low bit up)       | tlast
//  req     | in        | [15:0] pixel word        | end of image
//  rsp     | out       | [15:0] outline bits      | last result of image
//  csr     | in        | [4:0] words per row      | -
//
// An ordinary word is read from the row stores, then evaluated; a row-ending word
// also emits its last column, except in the first row of an image. A row-ending
// word with end of image adds a flush of the final row. Rate is set by the
// registered read of the two row stores; a new word waits until the last is done.
// Reset clears control and the above-row valid bits at once; no clearing pass.
// A held result stalls the sequencer only when the next result is due.
`timescale 1ns / 1ps

module glyph_outline_3x3 import go3_pkg::*; #(
   parameter int MAX_ROW_WORDS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [WORD_W-1:0] req_tdata,   // [15:0] pixel_word
   input  logic              req_tlast,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [WORD_W-1:0] rsp_tdata,   // [15:0] outline_bits
   output logic              rsp_tlast,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CSR_W-1:0]  csr_data     // [4:0] words_per_row
);

   localparam int IW = (MAX_ROW_WORDS > 1) ? $clog2(MAX_ROW_WORDS) : 1;

   ctl_cmd_type   cmd;
   logic [IW-1:0] rd_addr;
   logic [IW-1:0] wr_addr;
   logic          out_free;

   go3_ctrl #(
      .MAX_ROW_WORDS (MAX_ROW_WORDS),
      .IW            (IW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .out_free   (out_free),
      .cmd        (cmd),
      .rd_addr    (rd_addr),
      .wr_addr    (wr_addr)
   );

   go3_datapath #(
      .MAX_ROW_WORDS (MAX_ROW_WORDS),
      .IW            (IW)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .rd_addr    (rd_addr),
      .wr_addr    (wr_addr),
      .req_tdata  (req_tdata),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== test/glyph_outline_3x3_tb.sv =====
// Self-checking testbench for the streaming 3x3 glyph outline block.
`timescale 1ns / 1ps

module glyph_outline_3x3_tb;
   import go3_pkg::*;

   localparam int ROW_WORDS_MAX = 16;
   localparam int FLUSH_TAIL    = 32;   // covers the end-of-image flush of the widest row

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              end_flag;
   } pixel_item_type;

   typedef struct packed {
      logic [WORD_W-1:0] bits;
      logic              last_flag;
   } outline_result_type;

   typedef enum int {PAT_RANDOM, PAT_SPARSE, PAT_DENSE, PAT_EDGE} pattern_kind_type;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [WORD_W-1:0] req_tdata  = '0;
   logic              req_tlast  = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [WORD_W-1:0] rsp_tdata;
   logic              rsp_tlast;
   logic              csr_valid  = 1'b0;
   logic              csr_ready;
   logic [CSR_W-1:0]  csr_data   = '0;

   pixel_item_type     pending_words[$];
   outline_result_type expected_outlines[$];
   pixel_item_type     next_item;
   outline_result_type want;

   int  send_idle_pct = 30;
   int  recv_idle_pct = 30;
   bit  sender_hold   = 1'b0;
   bit  recv_hold     = 1'b0;
   int  mismatch_count = 0;
   int  items_queued   = 0;
   int  items_accepted = 0;
   event start_long_hold;

   // shadow of the block state
   logic [WORD_W-1:0] above_mem [ROW_WORDS_MAX];
   logic [WORD_W-1:0] middle_mem[ROW_WORDS_MAX];
   int unsigned       col_pos;
   bit                have_row;
   logic [WORD_W-1:0] prior_below;
   logic              left_up, left_mid, left_down;
   logic [CSR_W-1:0]  row_words_cfg;

   glyph_outline_3x3 #(.MAX_ROW_WORDS(ROW_WORDS_MAX)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int unsigned active_words(input logic [CSR_W-1:0] cfg);
      if (cfg == 0) return 1;
      if (cfg > ROW_WORDS_MAX) return ROW_WORDS_MAX;
      return 32'(cfg);
   endfunction

   // bit i of the word sits at index i+1 of the padded rows
   function automatic logic [WORD_W-1:0] outline_of(
      input logic [WORD_W-1:0] up, input logic [WORD_W-1:0] mid,
      input logic [WORD_W-1:0] down,
      input logic lu, input logic lm, input logic ld,
      input logic ru, input logic rm, input logic rd);
      logic [WORD_W+1:0] pu;
      logic [WORD_W+1:0] pm;
      logic [WORD_W+1:0] pd;
      logic [WORD_W-1:0] res;
      pu = {lu, up, ru};
      pm = {lm, mid, rm};
      pd = {ld, down, rd};
      for (int i = 0; i < WORD_W; i++) begin
         res[i] = !pm[i+1] && (pu[i] || pu[i+1] || pu[i+2] || pm[i] || pm[i+2]
                               || pd[i] || pd[i+1] || pd[i+2]);
      end
      return res;
   endfunction

   task automatic clear_shadow();
      for (int k = 0; k < ROW_WORDS_MAX; k++) begin
         above_mem[k]  = '0;
         middle_mem[k] = '0;
      end
      col_pos     = 0;
      have_row    = 1'b0;
      prior_below = '0;
      left_up     = 1'b0;
      left_mid    = 1'b0;
      left_down   = 1'b0;
   endtask

   task automatic push_outline(input logic [WORD_W-1:0] bits, input logic last_flag);
      outline_result_type r;
      r.bits      = bits;
      r.last_flag = last_flag;
      expected_outlines.push_back(r);
   endtask

   // one accepted pixel word: queue the outline words it releases
   task automatic predict_outline(input logic [WORD_W-1:0] w, input logic end_flag);
      int unsigned j;
      int unsigned k;
      bit          row_done;
      logic        ru;
      logic        rm;
      j        = col_pos % ROW_WORDS_MAX;
      row_done = (j + 1 >= active_words(row_words_cfg));
      if (!have_row) begin
         middle_mem[j] = w;
      end else begin
         if (j >= 1) begin
            k = j - 1;
            push_outline(outline_of(above_mem[k], middle_mem[k], prior_below,
                                    left_up, left_mid, left_down,
                                    above_mem[j][WORD_W-1], middle_mem[j][WORD_W-1],
                                    w[WORD_W-1]), 1'b0);
            left_up       = above_mem[k][0];
            left_mid      = middle_mem[k][0];
            left_down     = prior_below[0];
            above_mem[k]  = middle_mem[k];
            middle_mem[k] = prior_below;
         end
         prior_below = w;
         if (row_done) begin
            push_outline(outline_of(above_mem[j], middle_mem[j], w,
                                    left_up, left_mid, left_down, 1'b0, 1'b0, 1'b0), 1'b0);
            above_mem[j]  = middle_mem[j];
            middle_mem[j] = w;
         end
      end
      if (!row_done) begin
         col_pos = j + 1;
         return;
      end
      have_row  = 1'b1;
      col_pos   = 0;
      left_up   = 1'b0;
      left_mid  = 1'b0;
      left_down = 1'b0;
      if (end_flag) begin
         // flush the last row against a blank row below
         for (k = 0; k <= j; k++) begin
            ru = (k < j) ? above_mem[k+1][WORD_W-1] : 1'b0;
            rm = (k < j) ? middle_mem[k+1][WORD_W-1] : 1'b0;
            push_outline(outline_of(above_mem[k], middle_mem[k], '0,
                                    left_up, left_mid, 1'b0, ru, rm, 1'b0), k == j);
            left_up  = above_mem[k][0];
            left_mid = middle_mem[k][0];
         end
         clear_shadow();
      end
   endtask

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("MISMATCH at %0t ns: %s", $time, what);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_words.size() != 0 && !sender_hold
             && $urandom_range(99) >= send_idle_pct) begin
            next_item   = pending_words.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= next_item.word;
            req_tlast  <= next_item.end_flag;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      forever begin
         @(start_long_hold);
         @(posedge clock);
         recv_hold <= 1'b1;
         repeat (400) @(posedge clock);
         recv_hold <= 1'b0;
      end
   end

   // monitor: predict on accepted items, check accepted results
   always @(posedge clock) begin
      if (reset) begin
         clear_shadow();
         row_words_cfg = WPR_RESET;
      end else begin
         if (csr_valid && csr_ready) row_words_cfg = csr_data;
         if (req_tvalid && req_tready) begin
            items_accepted++;
            predict_outline(req_tdata, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_outlines.size() == 0) begin
               report_mismatch($sformatf("unexpected result bits=%h last=%b",
                                         rsp_tdata, rsp_tlast));
            end else begin
               want = expected_outlines.pop_front();
               if (rsp_tdata !== want.bits)
                  report_mismatch($sformatf("outline bits %h, wanted %h", rsp_tdata, want.bits));
               if (rsp_tlast !== want.last_flag)
                  report_mismatch($sformatf("last flag %b, wanted %b (bits %h)",
                                            rsp_tlast, want.last_flag, want.bits));
            end
         end
      end
   end

   task automatic queue_word(input logic [WORD_W-1:0] word, input logic end_flag);
      pixel_item_type it;
      it.word     = word;
      it.end_flag = end_flag;
      pending_words.push_back(it);
      items_queued++;
   endtask

   function automatic logic [WORD_W-1:0] make_word(input pattern_kind_type kind);
      logic [WORD_W-1:0] w;
      case (kind)
         PAT_SPARSE: w = ($urandom_range(3) == 0) ? '0 : (16'h0001 << $urandom_range(15));
         PAT_DENSE:  w = 16'($urandom | $urandom);
         PAT_EDGE: begin
            case ($urandom_range(4))
               0:       w = 16'h0000;
               1:       w = 16'hFFFF;
               2:       w = 16'h8000;
               3:       w = 16'h0001;
               default: w = 16'h8001;
            endcase
         end
         default:    w = 16'($urandom);
      endcase
      return w;
   endfunction

   // stray end flags go only on words that do not end a row, where they are ignored
   task automatic queue_image(input int unsigned width, input int unsigned rows,
                              input bit stray_ends);
      pattern_kind_type kind;
      logic             flag;
      kind = pattern_kind_type'($urandom_range(3));
      for (int unsigned r = 0; r < rows; r++) begin
         for (int unsigned c = 0; c < width; c++) begin
            if (r == rows - 1 && c == width - 1) flag = 1'b1;
            else if (stray_ends && c != width - 1 && $urandom_range(7) == 0) flag = 1'b1;
            else flag = 1'b0;
            queue_word(make_word(kind), flag);
         end
      end
   endtask

   task automatic settle_stream();
      @(negedge clock);
      while (pending_words.size() != 0 || req_tvalid || expected_outlines.size() != 0)
         @(negedge clock);
      repeat (FLUSH_TAIL) @(negedge clock);
   endtask

   task automatic write_row_words(input logic [CSR_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      int unsigned      sel;
      int unsigned      width;
      int unsigned      rows;
      int unsigned      images;
      logic [CSR_W-1:0] cfg;
      int               mark;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset width of one word
      queue_word(16'h0001, 1'b0);
      queue_word(16'h8000, 1'b0);
      queue_word(16'hFFFF, 1'b1);
      settle_stream();
      queue_word(16'h0100, 1'b1);        // single-row image
      settle_stream();

      write_row_words(5'd0);             // zero width acts as one word
      queue_word(16'h0000, 1'b1);
      queue_word(16'h7FFE, 1'b0);
      queue_word(16'h0000, 1'b1);
      settle_stream();

      write_row_words(5'd2);             // pixels across the word boundary
      queue_word(16'h0001, 1'b0);
      queue_word(16'h8000, 1'b0);
      queue_word(16'h0000, 1'b1);        // end flag mid-row is ignored
      queue_word(16'h0000, 1'b1);
      settle_stream();

      write_row_words(5'd31);            // clamps to the widest row
      for (int i = 0; i < ROW_WORDS_MAX; i++)
         queue_word((i % 2) ? 16'h8001 : 16'hFFFF, i == ROW_WORDS_MAX - 1);
      settle_stream();

      // receiver holds off while the sender keeps pushing
      write_row_words(5'd16);
      send_idle_pct <= 0;
      queue_image(ROW_WORDS_MAX, 6, 1'b1);
      -> start_long_hold;
      settle_stream();

      // a stretch with no idling on either side
      recv_idle_pct <= 0;
      write_row_words(5'd3);
      queue_image(3, 8, 1'b1);
      settle_stream();
      send_idle_pct <= 30;
      recv_idle_pct <= 30;

      // sender pauses mid-image until all due results are out
      write_row_words(5'd4);
      mark = items_accepted;
      queue_image(4, 5, 1'b0);
      while (items_accepted < mark + 10) @(negedge clock);
      @(posedge clock);
      sender_hold <= 1'b1;
      @(negedge clock);
      while (expected_outlines.size() != 0) @(negedge clock);
      repeat (FLUSH_TAIL) @(negedge clock);
      @(posedge clock);
      sender_hold <= 1'b0;
      settle_stream();

      while (items_queued < 280) begin
         sel = $urandom_range(9);
         if (sel < 6)      cfg = CSR_W'($urandom_range(4, 1));
         else if (sel < 8) cfg = CSR_W'($urandom_range(16, 5));
         else              cfg = CSR_W'($urandom_range(31, 0));
         write_row_words(cfg);
         width  = active_words(cfg);
         images = $urandom_range(3, 1);
         for (int n = 0; n < images; n++) begin
            rows = (width > 8) ? $urandom_range(3, 1) : $urandom_range(6, 1);
            queue_image(width, rows, $urandom_range(1));
         end
         settle_stream();
      end

      if (expected_outlines.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_outlines.size()));
      if (mismatch_count == 0) begin
         $display("glyph_outline_3x3 verification clean");
      end else begin
         $display("glyph_outline_3x3 verification failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("glyph_outline_3x3 verification failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/go3_pkg.sv
src/go3_datapath.sv
src/go3_ctrl.sv
src/glyph_outline_3x3.sv
test/glyph_outline_3x3_tb.sv
